[src/lipk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lipk_pkg
// Shared types, codes and constants of the last-input-priority key resolver.
// ----------------------------------------------------------------------------
package lipk_pkg;

	localparam int KEY_SLOTS = 8;
	localparam int GROUPS    = 4;

	localparam int KEY_W   = 8;
	localparam int GFLD_W  = 2;
	localparam int SLOT_W  = $clog2(KEY_SLOTS);
	localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	// result actions
	localparam logic [1:0] ACT_PASS    = 2'd0;
	localparam logic [1:0] ACT_SWALLOW = 2'd1;
	localparam logic [1:0] ACT_EMIT    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKED      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_KEYS   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_GROUPS = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ENABLE = 4'd3;

	localparam logic [63:0] SLOT_KEYS_RST   = 64'h0000_0000_5753_4441;
	localparam logic [15:0] SLOT_GROUPS_RST = 16'h0050;
	localparam logic [7:0]  SLOT_ENABLE_RST = 8'h0F;

	typedef struct packed {
		logic        locked;
		logic [63:0] slot_keys;
		logic [15:0] slot_groups;
		logic [7:0]  slot_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [KEY_W-1:0] out_key;
		logic             out_down;
		logic             last;
	} res_t;

	typedef struct packed {
		logic valid;
		logic two;
		res_t r0;
		res_t r1;
	} push_t;

	// group number folded into the configured group count
	function automatic logic [GRP_W-1:0] grp_fold(input logic [GFLD_W-1:0] v);
		logic [GFLD_W:0] t;
		t = {1'b0, v};
		if (GROUPS == 1) begin
			return '0;
		end else if (t >= (GFLD_W+1)'(GROUPS)) begin
			t = t - (GFLD_W+1)'(GROUPS);
		end
		return t[GRP_W-1:0];
	endfunction

endpackage
`default_nettype wire

[src/lipk_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lipk_in_if / lipk_out_if
// Valid/ready channels for key events and resolved results.
// ----------------------------------------------------------------------------
interface lipk_in_if;
	logic                      valid;
	logic                      ready;
	logic [lipk_pkg::KEY_W-1:0] key_code;
	logic                      op;
	logic                      injected;

	modport source (output valid, output key_code, output op, output injected, input ready);
	modport sink   (input valid, input key_code, input op, input injected, output ready);
endinterface

interface lipk_out_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic [lipk_pkg::KEY_W-1:0] out_key;
	logic                      out_down;
	logic                      last;

	modport source (output valid, output action, output out_key, output out_down,
		output last, input ready);
	modport sink   (input valid, input action, input out_key, input out_down,
		input last, output ready);
endinterface
`default_nettype wire

[src/lipk_cfg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lipk_cfg
// Configuration registers: lock flag, slot key codes, groups and enables.
// ----------------------------------------------------------------------------
module lipk_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               we,
	input  wire logic [lipk_pkg::CFG_IDX_W-1:0]     index,
	input  wire logic [lipk_pkg::CFG_DATA_W-1:0]    data,
	output lipk_pkg::cfg_t                          cfg
);
	import lipk_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.locked      <= 1'b0;
			cfg_q.slot_keys   <= SLOT_KEYS_RST;
			cfg_q.slot_groups <= SLOT_GROUPS_RST;
			cfg_q.slot_enable <= SLOT_ENABLE_RST;
		end else if (we) begin
			unique case (index)
				CFG_LOCKED:      cfg_q.locked      <= data[0];
				CFG_SLOT_KEYS:   cfg_q.slot_keys   <= data;
				CFG_SLOT_GROUPS: cfg_q.slot_groups <= data[15:0];
				CFG_SLOT_ENABLE: cfg_q.slot_enable <= data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[src/lipk_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lipk_core
// Input register, slot match and per-group resolution state. Each fired item
// pushes one or two results into the result queue; a hit updates the state.
// ----------------------------------------------------------------------------
module lipk_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lipk_pkg::cfg_t cfg,
	lipk_in_if.sink             in_ch,
	input  wire logic [1:0]     free_slots,
	output lipk_pkg::push_t     push
);
	import lipk_pkg::*;

	logic             s1_valid;
	logic [KEY_W-1:0] s1_key;
	logic             s1_rel;
	logic             s1_inj;

	logic [KEY_SLOTS-1:0] held_q;
	logic [KEY_W-1:0]     act_q  [GROUPS];
	logic [KEY_W-1:0]     disp_q [GROUPS];

	logic              found;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic [GRP_W-1:0]  grp;
	logic [KEY_W-1:0]  act;
	logic [KEY_W-1:0]  disp;
	logic              h;
	logic              held_n;
	logic [KEY_W-1:0]  act_n;
	logic [KEY_W-1:0]  disp_n;
	res_t              r0;
	res_t              r1;
	logic              two;
	logic              fire;

	always_comb begin
		found = 1'b0;
		slot  = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (!found && cfg.slot_enable[i] && cfg.slot_keys[KEY_W*i +: KEY_W] == s1_key) begin
				found = 1'b1;
				slot  = SLOT_W'(i);
			end
		end
		hit  = found && (s1_key != '0) && !cfg.locked && !s1_inj;
		grp  = grp_fold(cfg.slot_groups[GFLD_W*slot +: GFLD_W]);
		act  = act_q[grp];
		disp = disp_q[grp];
		h    = held_q[slot];

		held_n = h;
		act_n  = act;
		disp_n = disp;
		r0     = '{action: ACT_PASS, out_key: '0, out_down: 1'b0, last: 1'b1};
		r1     = '{action: ACT_PASS, out_key: '0, out_down: 1'b0, last: 1'b1};
		two    = 1'b0;

		if (hit) begin
			if (!s1_rel) begin
				if (h) begin
					r0.action = ACT_SWALLOW;
				end else begin
					held_n = 1'b1;
					act_n  = s1_key;
					r0     = '{action: ACT_EMIT, out_key: s1_key, out_down: 1'b1, last: 1'b1};
					if (act != '0 && act != s1_key) begin
						// new key takes over, release the one it pushed aside
						disp_n  = act;
						r0.last = 1'b0;
						r1      = '{action: ACT_EMIT, out_key: act, out_down: 1'b0, last: 1'b1};
						two     = 1'b1;
					end
				end
			end else begin
				if (!h) begin
					if (disp == s1_key) begin
						disp_n = '0;
					end
					r0.action = ACT_SWALLOW;
				end else begin
					held_n = 1'b0;
					disp_n = '0;
					r0     = '{action: ACT_EMIT, out_key: s1_key, out_down: 1'b0, last: 1'b1};
					if (act == s1_key && disp != '0) begin
						// active key let go, displaced key comes back
						act_n   = disp;
						r0.last = 1'b0;
						r1      = '{action: ACT_EMIT, out_key: disp, out_down: 1'b1, last: 1'b1};
						two     = 1'b1;
					end else if (act == s1_key) begin
						act_n = '0;
					end
				end
			end
		end
	end

	assign fire        = s1_valid && (free_slots >= (two ? 2'd2 : 2'd1));
	assign in_ch.ready = !s1_valid || fire;

	assign push.valid = fire;
	assign push.two   = two;
	assign push.r0    = r0;
	assign push.r1    = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			s1_key <= in_ch.key_code;
			s1_rel <= in_ch.op;
			s1_inj <= in_ch.injected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int g = 0; g < GROUPS; g++) begin
				act_q[g]  <= '0;
				disp_q[g] <= '0;
			end
		end else if (fire && hit) begin
			held_q[slot] <= held_n;
			act_q[grp]   <= act_n;
			disp_q[grp]  <= disp_n;
		end
	end

endmodule
`default_nettype wire

[src/lipk_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lipk_outq
// Two-entry result queue feeding the output channel one result per transfer.
// ----------------------------------------------------------------------------
module lipk_outq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lipk_pkg::push_t push,
	output logic [1:0]           free_slots,
	lipk_out_if.source           out_ch
);
	import lipk_pkg::*;

	res_t       ent_q [2];
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] cnt_pop;
	res_t       nxt0;
	res_t       nxt1;
	logic [1:0] cnt_n;

	assign out_ch.valid    = (cnt_q != 2'd0);
	assign out_ch.action   = ent_q[0].action;
	assign out_ch.out_key  = ent_q[0].out_key;
	assign out_ch.out_down = ent_q[0].out_down;
	assign out_ch.last     = ent_q[0].last;

	assign pop        = out_ch.valid && out_ch.ready;
	assign cnt_pop    = cnt_q - {1'b0, pop};
	assign free_slots = 2'd2 - cnt_pop;

	always_comb begin
		nxt0  = pop ? ent_q[1] : ent_q[0];
		nxt1  = ent_q[1];
		cnt_n = cnt_pop;
		if (push.valid) begin
			if (cnt_pop == 2'd0) begin
				nxt0 = push.r0;
				nxt1 = push.r1;
			end else begin
				nxt1 = push.r0;
			end
			cnt_n = cnt_pop + (push.two ? 2'd2 : 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		ent_q[0] <= nxt0;
		ent_q[1] <= nxt1;
	end

endmodule
`default_nettype wire

[src/last_input_priority_key_resolver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// last_input_priority_key_resolver
// Last-input-priority resolution of opposing key presses within key groups.
// ----------------------------------------------------------------------------
// An event transferred on in_ch is registered in the input register, resolved
// there and its results are written into a two-entry result queue that drives
// out_ch. Each event yields one or two results, the final one marked by last.
// Results leave the queue at one per cycle while out_ch is ready, so
// single-result events sustain one per cycle; a two-result event fills
// both queue entries, and the queue drain rate sets throughput under
// back-pressure. Configuration writes take effect on
// the next cycle and should be made while no event is in flight.
module last_input_priority_key_resolver (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lipk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lipk_pkg::CFG_DATA_W-1:0]  cfg_data,
	lipk_in_if.sink                               in_ch,
	lipk_out_if.source                            out_ch
);
	import lipk_pkg::*;

	cfg_t       cfg;
	push_t      push;
	logic [1:0] free_slots;

	lipk_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lipk_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_ch      (in_ch),
		.free_slots (free_slots),
		.push       (push)
	);

	lipk_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.free_slots (free_slots),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire
